### rtl/core/psedit_pkg.sv
package psedit_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned PosW         = 11;
  localparam int unsigned ValW         = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StatusW      = 2;

  // Byte-aligned width of the request tdata: position, then value.
  localparam int unsigned InDataW  = ((PosW + ValW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ValW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_CHANGE = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_e;

endpackage

### rtl/core/positional_sequence_editor_top.sv
// Channel   | tvalid/tready    | tuser             | tdata
// request   | s_tvalid_i/_o    | op [2:0]          | position [10:0], value [42:11], zero pad
// result    | m_tvalid_o/_i    | status [1:0]      | read_value [31:0]
//
// One request at a time; shifts use a simple dual-port memory, one element a cycle.
// Insert shifts the tail up and then writes the value, delete shifts the tail down,
// change writes in place; read, clear and rejected requests go straight to the result.
// Reset empties the sequence at once; no clearing pass over the memory.
// A finished result waits in the output register while the next request is
// accepted; only the last cycle of a request stalls on a full output.
module positional_sequence_editor_top #(
  parameter int unsigned DEPTH = psedit_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [psedit_pkg::OpW-1:0]     s_tuser_i,  // op
  input  logic [psedit_pkg::InDataW-1:0] s_tdata_i,  // position, value, zero pad
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [psedit_pkg::StatusW-1:0] m_tuser_o,  // status
  output logic [psedit_pkg::OutDataW-1:0] m_tdata_o  // read_value
);
  import psedit_pkg::*;

  localparam int unsigned LenW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW  = (LenW > PosW) ? LenW : PosW;

  logic [ValW-1:0] mem [DEPTH];

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic            out_valid_q;
  logic [ValW-1:0] out_data_q;
  status_e         out_status_q;

  op_e             op_q;
  logic [LenW-1:0] pos_q;
  logic [ValW-1:0] val_q;
  status_e         status_q, status_in;
  logic [LenW-1:0] ptr_q, ptr_d;
  logic [ValW-1:0] rdata_q;

  op_e             op_in;
  logic [PosW-1:0] pos_raw;
  logic [ValW-1:0] val_in;
  logic [CmpW-1:0] pos_ext, len_ext;
  logic [LenW-1:0] pos_in;
  logic            accept, ok_in, shift_last, out_load;

  logic            rd_en, wr_en;
  logic [LenW-1:0] rd_ptr, wr_ptr;
  logic [ValW-1:0] wr_data;

  assign op_in   = op_e'(s_tuser_i);
  assign pos_raw = s_tdata_i[PosW-1:0];
  assign val_in  = s_tdata_i[PosW+ValW-1:PosW];
  assign pos_ext = CmpW'(pos_raw);
  assign len_ext = CmpW'(len_q);
  assign pos_in  = pos_ext[LenW-1:0];

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign ok_in      = (status_in == ST_OK);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || m_tready_i);

  // The insert shift runs downwards and ends once the slot after the
  // position is filled; the delete shift runs upwards to the last entry.
  assign shift_last = (op_q == OP_INSERT) ? (ptr_q == LenW'(pos_q + LenW'(1)))
                                          : (LenW'(ptr_q + LenW'(2)) == len_q);

  always_comb begin
    status_in = ST_OK;
    case (op_in)
      OP_INSERT: begin
        if (pos_ext > len_ext) begin
          status_in = ST_RANGE;
        end else if (len_q == LenW'(DEPTH)) begin
          status_in = ST_FULL;
        end
      end
      OP_DELETE, OP_CHANGE, OP_READ: begin
        if (pos_ext >= len_ext) begin
          status_in = ST_RANGE;
        end
      end
      default: status_in = ST_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          if (ok_in) begin
            case (op_in)
              OP_INSERT: state_d = (pos_in == len_q) ? S_PUT : S_SHIFT;
              OP_DELETE: state_d = (LenW'(pos_in + LenW'(1)) == len_q) ? S_DONE : S_SHIFT;
              OP_CHANGE: state_d = S_PUT;
              default:   state_d = S_DONE;
            endcase
          end
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_d = (op_q == OP_INSERT) ? S_PUT : S_DONE;
        end
      end
      S_PUT:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory control, pointer and length
  always_comb begin
    rd_en   = 1'b0;
    rd_ptr  = '0;
    wr_en   = 1'b0;
    wr_ptr  = ptr_q;
    wr_data = rdata_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    case (state_q)
      S_IDLE: begin
        if (accept && ok_in) begin
          case (op_in)
            OP_INSERT: begin
              rd_en  = (pos_in != len_q);
              rd_ptr = len_q - LenW'(1);
              ptr_d  = len_q;
            end
            OP_DELETE: begin
              rd_en  = (LenW'(pos_in + LenW'(1)) != len_q);
              rd_ptr = pos_in + LenW'(1);
              ptr_d  = pos_in;
            end
            OP_READ: begin
              rd_en  = 1'b1;
              rd_ptr = pos_in;
            end
            default: rd_en = 1'b0;
          endcase
        end
      end
      S_SHIFT: begin
        wr_en  = 1'b1;
        rd_en  = !shift_last;
        rd_ptr = (op_q == OP_INSERT) ? ptr_q - LenW'(2) : ptr_q + LenW'(2);
        ptr_d  = (op_q == OP_INSERT) ? ptr_q - LenW'(1) : ptr_q + LenW'(1);
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_ptr  = pos_q;
        wr_data = val_q;
      end
      S_DONE: begin
        if (out_load && (status_q == ST_OK)) begin
          case (op_q)
            OP_INSERT: len_d = len_q + LenW'(1);
            OP_DELETE: len_d = len_q - LenW'(1);
            OP_CLEAR:  len_d = '0;
            default:   len_d = len_q;
          endcase
        end
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_ptr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (accept) begin
      op_q     <= op_in;
      pos_q    <= pos_in;
      val_q    <= val_in;
      status_q <= status_in;
    end
    if (out_load) begin
      out_status_q <= status_q;
      if (status_q != ST_OK) begin
        out_data_q <= '1;
      end else if (op_q == OP_READ) begin
        out_data_q <= rdata_q;
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = OutDataW'(out_data_q);

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(DEPTH))
    else $error("sequence length above capacity");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (ptr_q < LenW'(DEPTH)) && (ptr_q < len_q || op_q == OP_INSERT))
    else $error("shift pointer outside the live entries");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_tvalid_o && (state_q == S_IDLE))
    else $error("finished request did not reach the output register");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o != ST_OK) |-> (m_tdata_o == '1))
    else $error("rejected request returned a value other than all ones");

endmodule

### tb/tb_positional_sequence_editor_top.sv
module tb_positional_sequence_editor_top;
  import psedit_pkg::*;

  localparam int unsigned Depth      = DepthDefault;
  localparam int          OpCodeLast = (1 << OpW) - 1;
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] read_value;
  } reply_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [OpW-1:0]      s_tuser_i  = '0;  // op
  logic [InDataW-1:0]  s_tdata_i  = '0;  // position, value, zero pad
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [StatusW-1:0]  m_tuser_o;        // status
  logic [OutDataW-1:0] m_tdata_o;        // read_value

  // Own copy of the sequence, kept in step with every request handed over.
  logic [ValW-1:0] seq_mem [Depth];
  int unsigned     seq_len = 0;

  reply_t pending_replies [$];
  reply_t head_reply;
  int     mismatch_count = 0;
  int     idle_pct  = 0;
  int     stall_pct = 0;

  positional_sequence_editor_top #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tuser_i (s_tuser_i),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tuser_o (m_tuser_o),
    .m_tdata_o (m_tdata_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic reply_t edit_sequence(input logic [OpW-1:0] op,
                                           input logic [PosW-1:0] pos,
                                           input logic [ValW-1:0] val);
    reply_t      r;
    int unsigned p;
    r.status     = ST_OK;
    r.read_value = '0;
    p            = pos;
    case (op)
      OP_INSERT: begin
        // A bad position is reported ahead of a full store.
        if (p > seq_len) begin
          r.status = ST_RANGE;
        end else if (seq_len >= Depth) begin
          r.status = ST_FULL;
        end else begin
          for (int i = seq_len; i > p; i--) seq_mem[i] = seq_mem[i-1];
          seq_mem[p] = val;
          seq_len++;
        end
      end
      OP_DELETE: begin
        if (p >= seq_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i+1];
          seq_len--;
        end
      end
      OP_CHANGE: begin
        if (p >= seq_len) r.status = ST_RANGE;
        else seq_mem[p] = val;
      end
      OP_READ: begin
        if (p >= seq_len) r.status = ST_RANGE;
        else r.read_value = seq_mem[p];
      end
      OP_CLEAR: seq_len = 0;
      default: ;
    endcase
    if (r.status != ST_OK) r.read_value = '1;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    if (mismatch_count < 10) $display("mismatch: %s", msg);
    mismatch_count++;
  endfunction

  // Result side: random back-pressure and comparison against the oldest reply.
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("unexpected item status %0d value %h", m_tuser_o, m_tdata_o));
      end else begin
        head_reply = pending_replies.pop_front();
        if (m_tuser_o !== head_reply.status || m_tdata_o !== head_reply.read_value) begin
          flag_error($sformatf("expected status %0d value %h, got status %0d value %h",
                               head_reply.status, head_reply.read_value,
                               m_tuser_o, m_tdata_o));
        end
      end
    end
  end

  task automatic send_request(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] val);
    logic [InDataW-1:0] word;
    word                = '0;
    word[PosW-1:0]      = pos;
    word[PosW +: ValW]  = val;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    pending_replies.push_back(edit_sequence(op, pos, val));
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= word;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // The last item is already taken, so the sender goes quiet while waiting.
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_sequence();
    send_request(OP_READ, 0, $urandom);
    send_request(OP_DELETE, 0, $urandom);
    send_request(OP_CHANGE, 0, $urandom);
    send_request(OP_INSERT, 1, $urandom);
    send_request(OP_READ, PosW'(Depth), $urandom);
  endtask

  task automatic test_edit_and_read();
    send_request(OP_INSERT, 0, ValMin);
    send_request(OP_INSERT, 1, ValMax);
    send_request(OP_INSERT, 0, '1);
    send_request(OP_INSERT, 1, '0);
    for (int i = 0; i < 4; i++) send_request(OP_READ, PosW'(i), $urandom);
    send_request(OP_CHANGE, 2, 32'h5555_5555);
    send_request(OP_READ, 2, $urandom);
    send_request(OP_DELETE, 1, $urandom);
    send_request(OP_READ, 1, $urandom);
    send_request(OP_DELETE, 2, $urandom);
    send_request(OP_READ, 2, $urandom);
    send_request(OP_INSERT, 4, $urandom);
    send_request(OP_DELETE, PosW'(Depth), $urandom);
  endtask

  task automatic test_unused_codes();
    for (int c = OP_CLEAR + 1; c <= OpCodeLast; c++) begin
      send_request(c[OpW-1:0], PosW'($urandom_range(Depth)), $urandom);
    end
    send_request(OP_READ, 0, $urandom);
  endtask

  task automatic test_clear();
    send_request(OP_CLEAR, PosW'(Depth), $urandom);
    send_request(OP_READ, 0, $urandom);
    send_request(OP_CHANGE, 0, $urandom);
  endtask

  // Mostly valid edits that keep the sequence a few dozen long, with some
  // out-of-range positions and the odd clear mixed in.
  task automatic test_random_edits(input int idle, input int stall, input int count);
    int              len;
    int              pick;
    int              grow;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) begin
      len  = seq_len;
      pick = $urandom_range(99);
      if (pick < 8) begin
        op  = OpW'($urandom_range(OP_READ));
        pos = ($urandom_range(3) == 0) ? PosW'(Depth) : PosW'($urandom_range(Depth, len + 1));
      end else if (pick < 10) begin
        op  = OP_CLEAR;
        pos = PosW'($urandom_range(Depth));
      end else begin
        grow = (len < 12) ? 60 : ((len < 40) ? 35 : 10);
        if (len == 0 || $urandom_range(99) < grow) begin
          op  = OP_INSERT;
          pos = PosW'($urandom_range(len));
        end else begin
          case ($urandom_range(2))
            0:       op = OP_DELETE;
            1:       op = OP_CHANGE;
            default: op = OP_READ;
          endcase
          pos = PosW'($urandom_range(len - 1));
        end
      end
      val = $urandom;
      if ($urandom_range(7) == 0) val = $urandom_range(1) ? ValMin : ValMax;
      send_request(op, pos, val);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_sequence();
    test_edit_and_read();
    test_unused_codes();
    test_clear();
    wait_drained();

    test_random_edits(0, 0, 138);
    test_random_edits(84, 0, 138);
    // Hold the sender back until every reply is in before stalling the receiver.
    wait_drained();
    test_random_edits(0, 84, 138);
    test_random_edits(37, 37, 138);
    s_tvalid_i <= 1'b0;

    wait_drained();
    repeat (Depth + 8) @(posedge clk_i);
    if (pending_replies.size() != 0) flag_error("replies still outstanding at the end");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
